// File: rtl/core/bfw_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bfw_pkg: shared types, constants and functions of the bilateral filter
// Holds the geometry constants, the sample store slot arithmetic, the range
// weight table and the structs that travel between the core's parts.
// ---------------------------------------------------------------------------
package bfw_pkg;

    localparam int HALF_WINDOW = 3;
    localparam int WIN         = 2 * HALF_WINDOW + 1;
    localparam int K_W         = $clog2(WIN);
    localparam int MAX_WIDTH   = 1024;
    localparam int ROW_LIMIT   = 4096;
    localparam int STORE_DEPTH = 2 * HALF_WINDOW * (MAX_WIDTH + 1) + 1;
    localparam int SLOT_W      = $clog2(STORE_DEPTH);

    localparam int W_W    = 11;
    localparam int H_W    = 13;
    localparam int COL_W  = 10;
    localparam int ROW_W  = 13;
    localparam int OROW_W = 12;
    localparam int PIX_W  = 8;
    localparam int TAP_W  = 16;
    localparam int LUT_W  = 17;

    // Raster index, and the reciprocal used to reduce it modulo the depth.
    localparam int          IDX_W     = 23;
    localparam int          MOD_SHIFT = 36;
    localparam int          MUL_W     = 24;
    localparam logic [23:0] MOD_MUL   = 24'd11172083;
    localparam int          PROD_W    = IDX_W + MUL_W;
    localparam int          QUO_W     = PROD_W - MOD_SHIFT;

    localparam logic [2:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_TAP_CENTER   = 3'd2;
    localparam logic [2:0] CFG_TAP_ONE      = 3'd3;
    localparam logic [2:0] CFG_TAP_TWO      = 3'd4;
    localparam logic [2:0] CFG_TAP_THREE    = 3'd5;
    localparam logic [2:0] CFG_RANGE_SCALE  = 3'd6;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [W_W-1:0]   width;
        logic [H_W-1:0]   height;
        logic             frame_end;
    } job_t;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] addr;
        logic [PIX_W-1:0]  data;
    } store_wr_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
    } store_rd_t;

    typedef struct packed {
        logic [TAP_W-1:0] tap_center;
        logic [TAP_W-1:0] tap_one;
        logic [TAP_W-1:0] tap_two;
        logic [TAP_W-1:0] tap_three;
        logic [TAP_W-1:0] range_scale;
    } filt_cfg_t;

    typedef logic [LUT_W-1:0] range_lut_t [256];

    // Gaussian range weight, entry k for x = k/32, Q1.16, by repeated
    // multiplication with a decaying step factor.
    function automatic range_lut_t build_range_lut();
        range_lut_t  lut;
        logic [63:0] g;
        logic [63:0] s;
        logic [63:0] q2;
        logic [63:0] decay;
        decay = 64'd4292870656;
        g     = 64'd1 << 32;
        s     = decay;
        q2    = (decay * decay + (64'd1 << 31)) >> 32;
        for (int k = 0; k < 256; k++) begin
            lut[k] = LUT_W'((g + 64'h8000) >> 16);
            g      = (g * s + (64'd1 << 31)) >> 32;
            s      = (s * q2 + (64'd1 << 31)) >> 32;
        end
        return lut;
    endfunction

    localparam range_lut_t RANGE_LUT = build_range_lut();

    // Second half of the modulo reduction: prod is idx * MOD_MUL, registered in
    // the cycle before. One correction covers any rounding of the quotient.
    function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx,
                                                 input logic [PROD_W-1:0] prod);
        logic [QUO_W-1:0] q;
        logic [IDX_W-1:0] r;
        q = prod[PROD_W-1:MOD_SHIFT];
        r = idx - IDX_W'(q) * IDX_W'(STORE_DEPTH);
        if (r >= IDX_W'(STORE_DEPTH)) begin
            r = r - IDX_W'(STORE_DEPTH);
        end
        return r[SLOT_W-1:0];
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/bfw_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bfw_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module bfw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/bfw_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bfw_queue: two-entry job queue
// Carries output jobs from the front end to the back end, first in first out.
// ---------------------------------------------------------------------------
module bfw_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire bfw_pkg::job_t push_job,
    input  wire logic          pop,
    output logic               empty,
    output bfw_pkg::job_t      pop_job
);
    import bfw_pkg::*;

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign empty   = (count_reg == 2'd0);
    assign pop_job = entry_reg[rd_ptr_reg];
    assign do_push = push && (count_reg != 2'd2);
    assign do_pop  = pop && !empty;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/bfw_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bfw_front: input front end of the bilateral filter
// Accepts words, keeps the input and output raster positions, writes samples
// into the store and queues a job for each output that becomes due.
// ---------------------------------------------------------------------------
module bfw_front (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic                    s_op,
    input  wire logic [7:0]              s_sample,
    input  wire logic [10:0]             width,
    input  wire logic [12:0]             height,
    input  wire logic                    back_busy,
    input  wire logic                    q_empty,
    output logic                         q_push,
    output bfw_pkg::job_t                q_job,
    output bfw_pkg::store_wr_t           store_wr
);
    import bfw_pkg::*;

    typedef enum logic [4:0] {
        F_IDLE   = 5'b00001,
        F_INDEX  = 5'b00010,
        F_DECIDE = 5'b00100,
        F_MODMUL = 5'b01000,
        F_WRITE  = 5'b10000
    } fstate_t;

    fstate_t            state_reg;
    logic               op_reg;
    logic [PIX_W-1:0]   sample_reg;
    logic [COL_W-1:0]   in_col_reg;
    logic [ROW_W-1:0]   in_row_reg;
    logic [COL_W-1:0]   emit_col_reg;
    logic [ROW_W-1:0]   emit_row_reg;
    logic [IDX_W-1:0]   rx_reg;
    logic [IDX_W-1:0]   e_reg;
    logic [IDX_W-1:0]   total_reg;
    logic [11:0]        lag_reg;
    logic [IDX_W-1:0]   wr_idx_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               fire_reg;
    job_t               job_reg;

    // Decision terms, valid in F_DECIDE.
    logic               complete;
    logic               restart;
    logic [IDX_W-1:0]   rx_v;
    logic [IDX_W-1:0]   e_v;
    logic [COL_W-1:0]   ecol_v;
    logic [ROW_W-1:0]   erow_v;
    logic [COL_W-1:0]   icol_v;
    logic [ROW_W-1:0]   irow_v;
    logic               fire;
    logic [COL_W:0]     ecol_inc;
    logic [COL_W:0]     icol_inc;

    assign s_ready = (state_reg == F_IDLE) && q_empty && !back_busy;

    always_comb begin
        complete = (rx_reg >= total_reg);
        restart  = (op_reg == OP_SAMPLE) && complete;
        rx_v     = restart ? '0 : rx_reg;
        e_v      = restart ? '0 : e_reg;
        ecol_v   = restart ? '0 : emit_col_reg;
        erow_v   = restart ? '0 : emit_row_reg;
        icol_v   = restart ? '0 : in_col_reg;
        irow_v   = restart ? '0 : in_row_reg;
        if (op_reg == OP_FLUSH) begin
            fire = complete && (e_v < total_reg);
        end else begin
            fire = (e_v < total_reg) &&
                   ({1'b0, rx_v} >= ({1'b0, e_v} + (IDX_W+1)'(lag_reg)));
        end
        ecol_inc = {1'b0, ecol_v} + (COL_W+1)'(1);
        icol_inc = {1'b0, icol_v} + (COL_W+1)'(1);
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            F_IDLE: begin
                op_reg     <= s_op;
                sample_reg <= s_sample;
            end
            F_INDEX: begin
                rx_reg    <= IDX_W'(in_row_reg) * IDX_W'(width) + IDX_W'(in_col_reg);
                e_reg     <= IDX_W'(emit_row_reg) * IDX_W'(width) + IDX_W'(emit_col_reg);
                total_reg <= IDX_W'(width) * IDX_W'(height);
                lag_reg   <= 12'(width) * 12'(HALF_WINDOW) + 12'(HALF_WINDOW);
            end
            F_DECIDE: begin
                wr_idx_reg        <= rx_v;
                job_reg.row       <= erow_v;
                job_reg.col       <= ecol_v;
                job_reg.width     <= width;
                job_reg.height    <= height;
                job_reg.frame_end <= (e_v == total_reg - IDX_W'(1));
            end
            F_MODMUL: begin
                prod_reg <= PROD_W'(wr_idx_reg) * PROD_W'(MOD_MUL);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= F_IDLE;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            emit_col_reg <= '0;
            emit_row_reg <= '0;
            fire_reg     <= 1'b0;
        end else begin
            case (state_reg)
                F_IDLE: begin
                    if (s_valid && s_ready) begin
                        state_reg <= F_INDEX;
                    end
                end
                F_INDEX: begin
                    state_reg <= F_DECIDE;
                end
                F_DECIDE: begin
                    fire_reg <= fire;
                    if (op_reg == OP_SAMPLE) begin
                        if (icol_inc >= (COL_W+1)'(width)) begin
                            in_col_reg <= '0;
                            in_row_reg <= irow_v + ROW_W'(1);
                        end else begin
                            in_col_reg <= icol_inc[COL_W-1:0];
                            in_row_reg <= irow_v;
                        end
                    end
                    if (fire) begin
                        if (ecol_inc >= (COL_W+1)'(width)) begin
                            emit_col_reg <= '0;
                            emit_row_reg <= erow_v + ROW_W'(1);
                        end else begin
                            emit_col_reg <= ecol_inc[COL_W-1:0];
                            emit_row_reg <= erow_v;
                        end
                    end else begin
                        emit_col_reg <= ecol_v;
                        emit_row_reg <= erow_v;
                    end
                    state_reg <= F_MODMUL;
                end
                F_MODMUL: begin
                    state_reg <= F_WRITE;
                end
                F_WRITE: begin
                    fire_reg  <= 1'b0;
                    state_reg <= F_IDLE;
                end
                default: begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    assign store_wr.we   = (state_reg == F_WRITE) && (op_reg == OP_SAMPLE);
    assign store_wr.addr = slot_of(wr_idx_reg, prod_reg);
    assign store_wr.data = sample_reg;
    assign q_push        = (state_reg == F_WRITE) && fire_reg;
    assign q_job         = job_reg;
endmodule
`default_nettype wire

// File: rtl/core/bfw_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bfw_back: filter back end
// Walks the window of one queued output position, accumulates the weighted
// sums, divides them and holds the result in the output register.
// ---------------------------------------------------------------------------
module bfw_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                q_empty,
    input  wire bfw_pkg::job_t       q_job,
    output logic                     q_pop,
    input  wire bfw_pkg::filt_cfg_t  fcfg,
    output bfw_pkg::store_rd_t       store_rd,
    input  wire logic [7:0]          rd_data,
    output logic                     back_busy,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [7:0]               m_filtered,
    output logic [9:0]               m_out_col,
    output logic [11:0]              m_out_row,
    output logic                     m_frame_end
);
    import bfw_pkg::*;

    typedef enum logic [11:0] {
        B_IDLE    = 12'b000000000001,
        B_ROWMUL  = 12'b000000000010,
        B_MODMUL  = 12'b000000000100,
        B_MODSUB  = 12'b000000001000,
        B_ADDR    = 12'b000000010000,
        B_DATA    = 12'b000000100000,
        B_COEF    = 12'b000001000000,
        B_TERM    = 12'b000010000000,
        B_ACC     = 12'b000100000000,
        B_DIVINIT = 12'b001000000000,
        B_DIV     = 12'b010000000000,
        B_OUT     = 12'b100000000000
    } bstate_t;

    localparam int NUM_W  = 62;
    localparam int DEN_W  = 54;
    localparam int REM_W  = 63;
    localparam int DSR_W  = DEN_W + PIX_W - 1;

    bstate_t            state_reg;
    job_t               job_reg;
    logic [K_W-1:0]     ky_reg;
    logic [K_W-1:0]     kx_reg;
    logic               center_reg;
    logic               row_in_reg;
    logic               inside_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [PIX_W-1:0]   centre_reg;
    logic [PIX_W-1:0]   val_reg;
    logic [31:0]        spatial_reg;
    logic [23:0]        diffprod_reg;
    logic [47:0]        coeff_reg;
    logic [55:0]        term_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [DSR_W-1:0]   dsr_reg;
    logic [PIX_W-1:0]   quo_reg;
    logic [2:0]         bit_reg;
    logic               m_valid_reg;
    logic [PIX_W-1:0]   filt_reg;
    logic [COL_W-1:0]   ocol_reg;
    logic [OROW_W-1:0]  orow_reg;
    logic               ofe_reg;

    logic [ROW_W:0]     y_off;
    logic [ROW_W:0]     y_pos;
    logic               row_in;
    logic [COL_W+1:0]   x_off;
    logic               col_in;
    logic [SLOT_W:0]    a_off;
    logic [SLOT_W:0]    a_sub;
    logic [SLOT_W-1:0]  rd_addr;
    logic [PIX_W-1:0]   v;
    logic [PIX_W-1:0]   diff;
    logic [7:0]         ix;
    logic               load_out;

    function automatic logic [TAP_W-1:0] tap_sel(input logic [K_W-1:0] k,
                                                input filt_cfg_t c);
        logic [TAP_W-1:0] t;
        case (k)
            3'd3:       t = c.tap_center;
            3'd2, 3'd4: t = c.tap_one;
            3'd1, 3'd5: t = c.tap_two;
            default:    t = c.tap_three;
        endcase
        return t;
    endfunction

    always_comb begin
        // Window offsets are carried with HALF_WINDOW added, so an offset
        // below zero shows up as a value below HALF_WINDOW.
        y_off  = {1'b0, job_reg.row} + (ROW_W+1)'(ky_reg);
        y_pos  = y_off - (ROW_W+1)'(HALF_WINDOW);
        row_in = (y_off >= (ROW_W+1)'(HALF_WINDOW)) &&
                 (y_off < (ROW_W+1)'(job_reg.height) + (ROW_W+1)'(HALF_WINDOW));
        x_off  = {2'b0, job_reg.col} + (COL_W+2)'(kx_reg);
        col_in = (x_off >= (COL_W+2)'(HALF_WINDOW)) &&
                 (x_off < (COL_W+2)'(job_reg.width) + (COL_W+2)'(HALF_WINDOW));
        a_off  = {1'b0, slot_reg} + (SLOT_W+1)'(kx_reg);
        a_sub  = a_off - (SLOT_W+1)'(HALF_WINDOW);
        if (a_off < (SLOT_W+1)'(HALF_WINDOW)) begin
            rd_addr = SLOT_W'(a_sub + (SLOT_W+1)'(STORE_DEPTH));
        end else if (a_sub >= (SLOT_W+1)'(STORE_DEPTH)) begin
            rd_addr = SLOT_W'(a_sub - (SLOT_W+1)'(STORE_DEPTH));
        end else begin
            rd_addr = a_sub[SLOT_W-1:0];
        end
        v    = inside_reg ? rd_data : '0;
        diff = (v > centre_reg) ? (v - centre_reg) : (centre_reg - v);
        ix   = (diffprod_reg[23:16] != 8'd0) ? 8'd255 : diffprod_reg[15:8];
    end

    assign store_rd.en   = (state_reg == B_ADDR);
    assign store_rd.addr = rd_addr;
    assign q_pop         = (state_reg == B_IDLE) && !q_empty;
    assign back_busy     = (state_reg != B_IDLE);
    assign load_out      = (state_reg == B_OUT) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        case (state_reg)
            B_IDLE: begin
                job_reg <= q_job;
                num_reg <= '0;
                den_reg <= '0;
            end
            B_ROWMUL: begin
                row_in_reg <= row_in;
                idx_reg    <= IDX_W'(y_pos[ROW_W-1:0]) * IDX_W'(job_reg.width) +
                              IDX_W'(job_reg.col);
            end
            B_MODMUL: begin
                prod_reg <= PROD_W'(idx_reg) * PROD_W'(MOD_MUL);
            end
            B_MODSUB: begin
                slot_reg <= slot_of(idx_reg, prod_reg);
            end
            B_ADDR: begin
                inside_reg  <= row_in_reg && col_in;
                spatial_reg <= 32'(tap_sel(ky_reg, fcfg)) * 32'(tap_sel(kx_reg, fcfg));
            end
            B_DATA: begin
                if (center_reg) begin
                    centre_reg <= rd_data;
                end
                val_reg      <= v;
                diffprod_reg <= 24'(diff) * 24'(fcfg.range_scale);
            end
            B_COEF: begin
                coeff_reg <= 48'(spatial_reg) * 48'(RANGE_LUT[ix]);
            end
            B_TERM: begin
                term_reg <= 56'(coeff_reg) * 56'(val_reg);
            end
            B_ACC: begin
                num_reg <= num_reg + NUM_W'(term_reg);
                den_reg <= den_reg + DEN_W'(coeff_reg);
            end
            B_DIVINIT: begin
                rem_reg <= REM_W'(num_reg) + REM_W'(den_reg >> 1);
                dsr_reg <= {den_reg, 7'b0};
                quo_reg <= centre_reg;
                bit_reg <= 3'd7;
            end
            B_DIV: begin
                if (rem_reg >= REM_W'(dsr_reg)) begin
                    rem_reg          <= rem_reg - REM_W'(dsr_reg);
                    quo_reg[bit_reg] <= 1'b1;
                end else begin
                    quo_reg[bit_reg] <= 1'b0;
                end
                dsr_reg <= dsr_reg >> 1;
                bit_reg <= bit_reg - 3'd1;
            end
            default: begin
            end
        endcase
        if (load_out) begin
            filt_reg <= quo_reg;
            ocol_reg <= job_reg.col;
            orow_reg <= job_reg.row[OROW_W-1:0];
            ofe_reg  <= job_reg.frame_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            ky_reg      <= '0;
            kx_reg      <= '0;
            center_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE: begin
                    if (!q_empty) begin
                        center_reg <= 1'b1;
                        ky_reg     <= K_W'(HALF_WINDOW);
                        state_reg  <= B_ROWMUL;
                    end
                end
                B_ROWMUL: begin
                    state_reg <= B_MODMUL;
                end
                B_MODMUL: begin
                    state_reg <= B_MODSUB;
                end
                B_MODSUB: begin
                    kx_reg    <= center_reg ? K_W'(HALF_WINDOW) : '0;
                    state_reg <= B_ADDR;
                end
                B_ADDR: begin
                    state_reg <= B_DATA;
                end
                B_DATA: begin
                    if (center_reg) begin
                        center_reg <= 1'b0;
                        ky_reg     <= '0;
                        state_reg  <= B_ROWMUL;
                    end else begin
                        state_reg <= B_COEF;
                    end
                end
                B_COEF: begin
                    state_reg <= B_TERM;
                end
                B_TERM: begin
                    state_reg <= B_ACC;
                end
                B_ACC: begin
                    if (kx_reg == K_W'(WIN - 1)) begin
                        if (ky_reg == K_W'(WIN - 1)) begin
                            state_reg <= B_DIVINIT;
                        end else begin
                            ky_reg    <= ky_reg + K_W'(1);
                            state_reg <= B_ROWMUL;
                        end
                    end else begin
                        kx_reg    <= kx_reg + K_W'(1);
                        state_reg <= B_ADDR;
                    end
                end
                B_DIVINIT: begin
                    // A zero weight sum returns the centre sample unchanged.
                    state_reg <= (den_reg == '0) ? B_OUT : B_DIV;
                end
                B_DIV: begin
                    if (bit_reg == 3'd0) begin
                        state_reg <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (load_out) begin
                        state_reg <= B_IDLE;
                    end
                end
                default: begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_filtered  = filt_reg;
    assign m_out_col   = ocol_reg;
    assign m_out_row   = orow_reg;
    assign m_frame_end = ofe_reg;
endmodule
`default_nettype wire

// File: rtl/core/bilateral_filter_window_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bilateral_filter_window_core: 7x7 bilateral filter over one 8-bit plane
// Samples arrive in raster order; each output is the range- and
// space-weighted mean of its 7x7 neighbourhood, released in raster order.
// ---------------------------------------------------------------------------
//
//  channel  direction  word contents
//  s_       in         op (sample or flush), sample
//  m_       out        filtered, out_col, out_row, frame_end
//  cfg_     in         register index, write data (always ready)
//
// A word is taken once the front end is idle, the job queue is empty and the
// back end has no job. A sample that releases no output passes the front end
// through accept, index products, decision, modulo reduction and store write.
// A word that releases an output adds back end work: the back end visits the
// 49 window positions one at a time through the single read port of the
// sample store, each through address, data, coefficient, term and accumulate
// steps along its multiply chain, then runs an 8-step restoring divide.
// The finished result sits in the output register; while m_ready stalls, input
// is still taken until the next result waits in B_OUT, which then stops it.
// Reset is synchronous and active low; the sample store is not cleared.
// ---------------------------------------------------------------------------
module bilateral_filter_window_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_op,
    input  wire logic [7:0]  s_sample,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_filtered,
    output logic [9:0]       m_out_col,
    output logic [11:0]      m_out_row,
    output logic             m_frame_end,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import bfw_pkg::*;

    logic [W_W-1:0] image_width_reg;
    logic [H_W-1:0] image_height_reg;
    filt_cfg_t      fcfg_reg;
    logic [W_W-1:0] width_eff;
    logic [H_W-1:0] height_eff;

    logic           q_push;
    logic           q_pop;
    logic           q_empty;
    job_t           push_job;
    job_t           pop_job;
    logic           back_busy;
    store_wr_t      store_wr;
    store_rd_t      store_rd;
    logic [7:0]     rd_data;

    // Configuration is always accepted. Unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg      <= W_W'(1024);
            image_height_reg     <= H_W'(1024);
            fcfg_reg.tap_center  <= 16'd65535;
            fcfg_reg.tap_one     <= 16'd39750;
            fcfg_reg.tap_two     <= 16'd8869;
            fcfg_reg.tap_three   <= 16'd728;
            fcfg_reg.range_scale <= 16'd273;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_reg      <= cfg_data[W_W-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg     <= cfg_data[H_W-1:0];
                CFG_TAP_CENTER:   fcfg_reg.tap_center  <= cfg_data;
                CFG_TAP_ONE:      fcfg_reg.tap_one     <= cfg_data;
                CFG_TAP_TWO:      fcfg_reg.tap_two     <= cfg_data;
                CFG_TAP_THREE:    fcfg_reg.tap_three   <= cfg_data;
                CFG_RANGE_SCALE:  fcfg_reg.range_scale <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A zero size counts as one; a width above the store's reach and a height above ROW_LIMIT are clamped.
    always_comb begin
        if (image_width_reg == '0) begin
            width_eff = W_W'(1);
        end else if (image_width_reg > W_W'(MAX_WIDTH)) begin
            width_eff = W_W'(MAX_WIDTH);
        end else begin
            width_eff = image_width_reg;
        end
        if (image_height_reg == '0) begin
            height_eff = H_W'(1);
        end else if (image_height_reg > H_W'(ROW_LIMIT)) begin
            height_eff = H_W'(ROW_LIMIT);
        end else begin
            height_eff = image_height_reg;
        end
    end

    bfw_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_op      (s_op),
        .s_sample  (s_sample),
        .width     (width_eff),
        .height    (height_eff),
        .back_busy (back_busy),
        .q_empty   (q_empty),
        .q_push    (q_push),
        .q_job     (push_job),
        .store_wr  (store_wr)
    );

    // Circular sample store, slot = raster index modulo its depth.
    bfw_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (store_wr.we),
        .wr_addr (store_wr.addr),
        .wr_data (store_wr.data),
        .rd_en   (store_rd.en),
        .rd_addr (store_rd.addr),
        .rd_data (rd_data)
    );

    bfw_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .empty    (q_empty),
        .pop_job  (pop_job)
    );

    bfw_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_empty     (q_empty),
        .q_job       (pop_job),
        .q_pop       (q_pop),
        .fcfg        (fcfg_reg),
        .store_rd    (store_rd),
        .rd_data     (rd_data),
        .back_busy   (back_busy),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_filtered  (m_filtered),
        .m_out_col   (m_out_col),
        .m_out_row   (m_out_row),
        .m_frame_end (m_frame_end)
    );
endmodule
`default_nettype wire
